@@ design/dmma_pkg.sv @@
// Shared types, codes and field widths for the dense matrix multiply-accumulate core.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package dmma_pkg;

   localparam int DMMA_MAX_DIM = 16;

   localparam int OP_W   = 3;
   localparam int ROW_W  = 4;
   localparam int COL_W  = 4;
   localparam int VAL_W  = 16;
   localparam int ACC_W  = 48;
   localparam int PROD_W = 2 * VAL_W;
   localparam int SIZE_W = 5;

   localparam int REQ_DATA_W = ROW_W + COL_W + VAL_W;
   localparam int RSP_DATA_W = ROW_W + COL_W + ACC_W;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_WR_A = 3'd0,
      OP_WR_B = 3'd1,
      OP_WR_C = 3'd2,
      OP_MUL  = 3'd3,
      OP_RD_C = 3'd4
   } dmma_op_type;

   // Controller to datapath.
   typedef struct packed {
      logic                    wr_a;
      logic                    wr_b;
      logic                    wr_c;
      logic                    clr_c;
      logic                    rd_c;
      logic                    rd_inside;
      logic                    mac_valid;
      logic                    mac_first;
      logic                    mac_last;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } dmma_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic mac_busy;
      logic rsp_room;
   } dmma_sts_type;

   // One result item, first field in the highest bits.
   typedef struct packed {
      logic signed [ACC_W-1:0] out_value;
      logic [COL_W-1:0]        out_col;
      logic [ROW_W-1:0]        out_row;
   } dmma_rsp_type;

endpackage

@@ design/dense_matrix_multiply_accumulate_core.sv @@
// Top level of the dense matrix multiply-accumulate core.
// Instantiates dmma_ctrl and dmma_dp; depends on dmma_pkg.
//
// The core holds three square matrices A, B and C of MAX_DIM by MAX_DIM entries,
// element (row, col) kept at row*MAX_DIM+col, and computes C += A*B over the
// leading size-by-size corner. A request transfer carries the operation in
// req_tuser (write A, write B, write C, multiply, read C) and row, column and a
// signed Q8.8 value in req_tdata. A and B are stored as given; a write to C
// stores the value in Q32.16. Only a read of C produces a response transfer,
// echoing row and column with the 48-bit signed Q32.16 element; a read outside
// MAX_DIM returns zero, a write outside MAX_DIM is dropped, unused codes are
// dropped. Products are exact Q16.16 and each add saturates to the 48-bit range.
// The size register (csr_wr_data, written while csr_wr_en is high) is clamped to
// 1..MAX_DIM when a multiply starts; write it only while the core is idle.
// Rate: element writes are taken one per cycle while the core is idle, and reads
// keep going at one per cycle while the response side accepts, with a two-entry
// result buffer absorbing stalls. A multiply walks all n*n*n index triples, where n
// is the clamped size, through one multiply-accumulate unit fed by one read port
// on each of A and B, then drains its pipeline. After reset a clearing sweep zeroes
// C one entry per cycle, and req_tready stays low until it finishes; size writes
// are taken during the sweep. A and B are not cleared: reading an entry that was
// never written gives an undefined product.
module dense_matrix_multiply_accumulate_core #(
   parameter int MAX_DIM = dmma_pkg::DMMA_MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration: size register
   input  logic                            csr_wr_en,
   input  logic [dmma_pkg::SIZE_W-1:0]     csr_wr_data,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dmma_pkg::OP_W-1:0]       req_tuser,  // op[2:0]
   input  logic [dmma_pkg::REQ_DATA_W-1:0] req_tdata,  // row[3:0], col[7:4], value[23:8]
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dmma_pkg::RSP_DATA_W-1:0] rsp_tdata   // out_row[3:0], out_col[7:4],
                                                       // out_value[55:8]
);
   import dmma_pkg::*;

   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   dmma_cmd_type  cmd;
   dmma_sts_type  sts;
   logic [AW-1:0] a_addr, b_addr, c_addr;

   // decode, clearing sweep and loop sequencing
   dmma_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .sts         (sts),
      .cmd         (cmd),
      .a_addr      (a_addr),
      .b_addr      (b_addr),
      .c_addr      (c_addr)
   );

   // memories, MAC pipeline and result buffer
   dmma_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .a_addr     (a_addr),
      .b_addr     (b_addr),
      .c_addr     (c_addr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ design/dmma_ctrl.sv @@
// Controller of the matrix core: request decode, clearing sweep and the i/j/k sequencer.
// Drives commands and addresses into dmma_dp and reads back its status.
// Depends on dmma_pkg.
module dmma_ctrl #(
   parameter int MAX_DIM = dmma_pkg::DMMA_MAX_DIM,
   localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [dmma_pkg::SIZE_W-1:0]   csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dmma_pkg::OP_W-1:0]     req_tuser,
   input  logic [dmma_pkg::REQ_DATA_W-1:0] req_tdata,
   input  dmma_pkg::dmma_sts_type        sts,
   output dmma_pkg::dmma_cmd_type        cmd,
   output logic [AW-1:0]                 a_addr,
   output logic [AW-1:0]                 b_addr,
   output logic [AW-1:0]                 c_addr
);
   import dmma_pkg::*;

   localparam int IW    = $clog2(MAX_DIM);
   localparam int NW    = $clog2(MAX_DIM + 1);
   localparam int CELLS = MAX_DIM * MAX_DIM;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MUL, ST_DRAIN} state_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [IW-1:0]           i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [NW-1:0]           n_ff, n_in, dim, n_m1;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [ROW_W-1:0]        row;
   logic [COL_W-1:0]        col;
   logic signed [VAL_W-1:0] value;
   logic                    in_range, accept, last_k, last_j, last_i;
   logic [AW-1:0]           item_addr;

   assign row   = req_tdata[ROW_W-1:0];
   assign col   = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign value = $signed(req_tdata[REQ_DATA_W-1:ROW_W+COL_W]);

   assign in_range  = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
   assign item_addr = in_range ? AW'(int'(row) * MAX_DIM + int'(col)) : '0;

   assign req_tready = (state_ff == ST_IDLE) && sts.rsp_room;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (size_ff == '0) begin
         dim = NW'(1);
      end else if (int'(size_ff) > MAX_DIM) begin
         dim = NW'(MAX_DIM);
      end else begin
         dim = NW'(size_ff);
      end
   end

   assign n_m1   = n_ff - NW'(1);
   assign last_k = (NW'(k_ff) == n_m1);
   assign last_j = (NW'(j_ff) == n_m1);
   assign last_i = (NW'(i_ff) == n_m1);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      size_in  = csr_wr_en ? csr_wr_data : size_ff;

      cmd       = '0;
      cmd.row   = row;
      cmd.col   = col;
      cmd.value = value;
      a_addr    = item_addr;
      b_addr    = item_addr;
      c_addr    = item_addr;

      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_c = 1'b1;
            c_addr    = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_WR_A: cmd.wr_a = in_range;
                  OP_WR_B: cmd.wr_b = in_range;
                  OP_WR_C: cmd.wr_c = in_range;
                  OP_MUL: begin
                     state_in = ST_MUL;
                     n_in     = dim;
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                  end
                  OP_RD_C: begin
                     cmd.rd_c      = 1'b1;
                     cmd.rd_inside = in_range;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            cmd.mac_valid = 1'b1;
            cmd.mac_first = (k_ff == '0);
            cmd.mac_last  = last_k;
            a_addr = AW'(int'(i_ff) * MAX_DIM + int'(k_ff));
            b_addr = AW'(int'(k_ff) * MAX_DIM + int'(j_ff));
            c_addr = AW'(int'(i_ff) * MAX_DIM + int'(j_ff));
            if (last_k) begin
               k_in = '0;
               if (last_j) begin
                  j_in = '0;
                  if (last_i) begin
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + IW'(1);
                  end
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            if (!sts.mac_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         n_ff     <= NW'(1);
         size_ff  <= SIZE_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         size_ff  <= size_in;
      end
   end

endmodule

@@ design/dmma_dp.sv @@
// Datapath of the matrix core: A, B and C memories, the multiply-accumulate pipeline
// and the two-entry result buffer. Commanded by dmma_ctrl.
// Depends on dmma_pkg.
module dmma_dp #(
   parameter int MAX_DIM = dmma_pkg::DMMA_MAX_DIM,
   localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dmma_pkg::dmma_cmd_type          cmd,
   output dmma_pkg::dmma_sts_type          sts,
   input  logic [AW-1:0]                   a_addr,
   input  logic [AW-1:0]                   b_addr,
   input  logic [AW-1:0]                   c_addr,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dmma_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dmma_pkg::*;

   localparam int CELLS = MAX_DIM * MAX_DIM;

   logic signed [VAL_W-1:0] a_mem [CELLS];
   logic signed [VAL_W-1:0] b_mem [CELLS];
   logic signed [ACC_W-1:0] c_mem [CELLS];

   logic signed [VAL_W-1:0]  a_q_ff, b_q_ff;
   logic signed [ACC_W-1:0]  c_q_ff;

   // stage 1: memory data out
   logic                     v1_ff, f1_ff, l1_ff;
   logic [AW-1:0]            wa1_ff;
   logic                     rd1_ff, rdin1_ff;
   logic [ROW_W-1:0]         row1_ff;
   logic [COL_W-1:0]         col1_ff;
   // stage 2: product
   logic                     v2_ff, f2_ff, l2_ff;
   logic [AW-1:0]            wa2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  c2_ff;
   // stage 3: accumulator
   logic signed [ACC_W-1:0]  acc_ff, acc_in, base;
   logic signed [ACC_W:0]    sum;

   logic                     mac_wr, c_we;
   logic [AW-1:0]            c_waddr;
   logic signed [ACC_W-1:0]  c_wdata;

   dmma_rsp_type             ent_ff [2];
   dmma_rsp_type             push_ent;
   logic [1:0]               cnt_ff, cnt_in;
   logic                     rptr_ff, wptr_ff, push, pop;
   logic [2:0]               occ;

   // accumulate with saturation after every add
   assign base = f2_ff ? c2_ff : acc_ff;
   assign sum  = {base[ACC_W-1], base} +
                 {{(ACC_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   always_comb begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_in = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = sum[ACC_W-1:0];
      end
   end

   assign mac_wr = v2_ff && l2_ff;
   assign c_we   = mac_wr || cmd.clr_c || cmd.wr_c;

   always_comb begin
      if (mac_wr) begin
         c_waddr = wa2_ff;
         c_wdata = acc_in;
      end else begin
         c_waddr = c_addr;
         c_wdata = cmd.clr_c ? '0 :
                   {{(ACC_W - VAL_W - 8){cmd.value[VAL_W-1]}}, cmd.value, 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem[a_addr] <= cmd.value;
      end
      a_q_ff <= a_mem[a_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         b_mem[b_addr] <= cmd.value;
      end
      b_q_ff <= b_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         c_mem[c_waddr] <= c_wdata;
      end
      c_q_ff <= c_mem[c_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         rd1_ff <= 1'b0;
      end else begin
         v1_ff  <= cmd.mac_valid;
         v2_ff  <= v1_ff;
         rd1_ff <= cmd.rd_c;
      end
   end

   always_ff @(posedge clock) begin
      f1_ff    <= cmd.mac_first;
      l1_ff    <= cmd.mac_last;
      wa1_ff   <= c_addr;
      rdin1_ff <= cmd.rd_inside;
      row1_ff  <= cmd.row;
      col1_ff  <= cmd.col;
      f2_ff    <= f1_ff;
      l2_ff    <= l1_ff;
      wa2_ff   <= wa1_ff;
      prod_ff  <= PROD_W'(a_q_ff) * PROD_W'(b_q_ff);
      c2_ff    <= c_q_ff;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   // result buffer
   assign push               = rd1_ff;
   assign pop                = rsp_tvalid && rsp_tready;
   assign push_ent.out_row   = row1_ff;
   assign push_ent.out_col   = col1_ff;
   assign push_ent.out_value = rdin1_ff ? c_q_ff : '0;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = ent_ff[rptr_ff];

   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);
   assign occ    = 3'(cnt_ff) + 3'(rd1_ff) - 3'(pop);

   assign sts.rsp_room = (occ < 3'd2);
   assign sts.mac_busy = v1_ff || v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         rptr_ff <= 1'b0;
         wptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wptr_ff] <= push_ent;
      end
   end

endmodule

@@ design/dmma_checker.sv @@
// Port-level checks for the dense matrix multiply-accumulate core, bound to the top level.
// Depends on dmma_pkg and dense_matrix_multiply_accumulate_core.
module dmma_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [dmma_pkg::OP_W-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dmma_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dmma_pkg::*;

   logic req_xfer;

   assign req_xfer = req_tvalid && req_tready;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // clearing sweep blocks requests, and nothing is pending out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("core not quiet after reset");

   // a multiply drops req_tready once it is taken
   a_mul_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tuser == OP_MUL) |=> !req_tready)
      else $error("request taken right after multiply");

   // a read of C shows a response once it has passed rd1_ff into the result buffer
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tuser == OP_RD_C) |=> ##1 rsp_tvalid)
      else $error("read produced no response");

endmodule

bind dense_matrix_multiply_accumulate_core dmma_checker u_checker (.*);

@@ bench/dmma_result_checker.sv @@
// Result checker for the dense matrix multiply-accumulate core: watches the size
// register, request and response channels, predicts every C read and compares it.
// Depends on dmma_pkg.
`timescale 1ns / 100ps

module dmma_result_checker
   import dmma_pkg::*;
#(
   parameter int MAX_DIM = DMMA_MAX_DIM
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SIZE_W-1:0]     csr_wr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [OP_W-1:0]       req_tuser,   // op[2:0]
   input  logic [REQ_DATA_W-1:0] req_tdata,   // row[3:0], col[7:4], value[23:8]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // out_row[3:0], out_col[7:4], out_value[55:8]
   input  logic                  end_of_run,
   output int                    reads_due,
   output int                    fail_count
);

   localparam int CELLS = MAX_DIM * MAX_DIM;

   logic signed [VAL_W-1:0] a_cells [CELLS];
   logic signed [VAL_W-1:0] b_cells [CELLS];
   logic signed [ACC_W-1:0] c_cells [CELLS];
   logic [SIZE_W-1:0]       size_reg;
   dmma_rsp_type            c_reads_due [$];
   bit                      tail_checked;

   initial begin
      fail_count   = 0;
      reads_due    = 0;
      tail_checked = 1'b0;
      size_reg     = SIZE_RESET;
      foreach (a_cells[i]) begin
         a_cells[i] = '0;
         b_cells[i] = '0;
         c_cells[i] = '0;
      end
   end

   task automatic report(input string what);
      $display("%0t C read check: %s", $time, what);
      fail_count++;
   endtask

   // C += A * B over the leading n-by-n corner, saturating after every add.
   task automatic accumulate_product();
      int     n;
      longint acc;
      longint prod;
      n = (size_reg == '0) ? 1 : (size_reg > MAX_DIM) ? MAX_DIM : int'(size_reg);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = longint'(c_cells[i * MAX_DIM + j]);
            for (int k = 0; k < n; k++) begin
               prod = longint'(a_cells[i * MAX_DIM + k]) * longint'(b_cells[k * MAX_DIM + j]);
               acc  = acc + prod;
               if (acc > longint'(ACC_MAX))
                  acc = longint'(ACC_MAX);
               else if (acc < longint'(ACC_MIN))
                  acc = longint'(ACC_MIN);
            end
            c_cells[i * MAX_DIM + j] = acc[ACC_W-1:0];
         end
      end
   endtask

   always @(posedge clock) begin
      logic [OP_W-1:0]         op;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
      bit                      in_range;
      int                      slot;
      dmma_rsp_type            want;
      dmma_rsp_type            got;
      if (reset) begin
         foreach (c_cells[i]) begin
            a_cells[i] = '0;
            b_cells[i] = '0;
            c_cells[i] = '0;
         end
         size_reg = SIZE_RESET;
         c_reads_due.delete();
      end else begin
         if (csr_wr_en)
            size_reg = csr_wr_data;

         if (req_tvalid && req_tready) begin
            op       = req_tuser;
            row      = req_tdata[ROW_W-1:0];
            col      = req_tdata[ROW_W +: COL_W];
            value    = req_tdata[ROW_W + COL_W +: VAL_W];
            in_range = (row < MAX_DIM) && (col < MAX_DIM);
            slot     = in_range ? row * MAX_DIM + col : 0;
            case (op)
               OP_WR_A: if (in_range) a_cells[slot] = value;
               OP_WR_B: if (in_range) b_cells[slot] = value;
               OP_WR_C: if (in_range) c_cells[slot] = ACC_W'(longint'(value) * 256);
               OP_MUL:  accumulate_product();
               OP_RD_C: begin
                  want.out_row   = row;
                  want.out_col   = col;
                  want.out_value = in_range ? c_cells[slot] : '0;
                  c_reads_due.push_back(want);
               end
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got = dmma_rsp_type'(rsp_tdata);
            if (c_reads_due.size() == 0) begin
               report($sformatf("response row %0d col %0d value %h with no read outstanding",
                                got.out_row, got.out_col, got.out_value));
            end else begin
               want = c_reads_due.pop_front();
               if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                   got.out_value !== want.out_value)
                  report($sformatf("C[%0d][%0d] got row %0d col %0d value %h, want %h",
                                   want.out_row, want.out_col, got.out_row, got.out_col,
                                   got.out_value, want.out_value));
            end
         end

         if (end_of_run && !tail_checked) begin
            tail_checked = 1'b1;
            if (c_reads_due.size() != 0)
               report($sformatf("%0d reads never answered", c_reads_due.size()));
         end
      end
      reads_due = c_reads_due.size();
   end

endmodule

@@ bench/dense_matrix_multiply_accumulate_core_test.sv @@
// Top of the regression for the dense matrix multiply-accumulate core: clock, reset,
// size register writes, request stimulus, response back-pressure and the verdict.
// Depends on dmma_pkg, dense_matrix_multiply_accumulate_core and dmma_result_checker.
`timescale 1ns / 100ps

module dense_matrix_multiply_accumulate_core_test;
   import dmma_pkg::*;

   localparam int CELLS       = DMMA_MAX_DIM * DMMA_MAX_DIM;
   localparam int ITEM_GOAL   = 1950;
   // A full-size multiply walks 16^3 index triples with nothing moving; allow several times as long.
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_SLACK = 16;

   localparam logic [OP_W-1:0]  OP_SPARE_LAST = '1;
   localparam logic [VAL_W-1:0] VAL_MAX       = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN       = {1'b1, {(VAL_W-1){1'b0}}};

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [SIZE_W-1:0]     csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [OP_W-1:0]       req_tuser;   // op[2:0]
   logic [REQ_DATA_W-1:0] req_tdata;   // row[3:0], col[7:4], value[23:8]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // out_row[3:0], out_col[7:4], out_value[55:8]
   logic                  end_of_run;
   int                    pending_reads;
   int                    fail_total;

   // Stimulus bookkeeping: which A and B entries hold a written value, the dimension
   // in use, and the size of the last multiply whose walk may still be running.
   bit a_known [CELLS];
   bit b_known [CELLS];
   int items_sent;
   int burst_left;
   int cur_n;
   int mul_walk_n;
   int idle_cycles;

   dense_matrix_multiply_accumulate_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   dmma_result_checker u_results (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .end_of_run  (end_of_run),
      .reads_due   (pending_reads),
      .fail_count  (fail_total)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly random Q8.8 values, with the two extremes mixed in often.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Present one request at the falling edge and hold it until the transfer.
   // The sender runs in bursts; open a new burst after a random gap.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 9)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {value, col, row};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      // Drop valid; a following call in the same burst may raise it again in this same step.
      req_tvalid = 1'b0;
      burst_left--;
      case (op)
         OP_WR_A: a_known[row * DMMA_MAX_DIM + col] = 1'b1;
         OP_WR_B: b_known[row * DMMA_MAX_DIM + col] = 1'b1;
         OP_MUL:  mul_walk_n = cur_n;
         default: ;
      endcase
      // Spare codes are ignored by the core; leave them out of the item count.
      if (op <= OP_RD_C)
         items_sent++;
   endtask

   // Hold the sender until every outstanding read has come back.
   task automatic wait_for_reads();
      while (pending_reads != 0) @(negedge clock);
   endtask

   // Bring the core to idle: drain reads, then let any multiply walk finish,
   // since a multiply produces no response to wait on.
   task automatic settle();
      wait_for_reads();
      repeat (mul_walk_n * mul_walk_n * mul_walk_n + DRAIN_SLACK) @(negedge clock);
      mul_walk_n = 0;
   endtask

   task automatic set_size(input logic [SIZE_W-1:0] value);
      settle();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      // Zero runs as one, anything past the array runs as the full array.
      cur_n = (value == '0) ? 1 : (value > DMMA_MAX_DIM) ? DMMA_MAX_DIM : int'(value);
   endtask

   // Load every A and B entry of the corner that was never written, then multiply:
   // the walk must never touch an undefined entry.
   task automatic start_multiply();
      for (int i = 0; i < cur_n; i++) begin
         for (int k = 0; k < cur_n; k++) begin
            if (!a_known[i * DMMA_MAX_DIM + k])
               send_item(OP_WR_A, ROW_W'(i), COL_W'(k), pick_value());
            if (!b_known[i * DMMA_MAX_DIM + k])
               send_item(OP_WR_B, ROW_W'(i), COL_W'(k), pick_value());
         end
      end
      send_item(OP_MUL, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
   endtask

   task automatic corner_read();
      send_item(OP_RD_C, ROW_W'($urandom_range(0, cur_n - 1)),
                COL_W'($urandom_range(0, cur_n - 1)), VAL_W'($urandom));
   endtask

   // One random request: mostly loads and reads inside the corner in use, some
   // outside it, occasional multiplies (rarer at large sizes) and spare codes.
   task automatic random_item();
      int unsigned      roll;
      int unsigned      mul_odds;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      mul_odds = (cur_n <= 4) ? 20 : (cur_n <= 8) ? 50 : 150;
      if ($urandom_range(0, 59) == 0)
         wait_for_reads();
      if ($urandom_range(0, 4) == 0) begin
         row = ROW_W'($urandom);
         col = COL_W'($urandom);
      end else begin
         row = ROW_W'($urandom_range(0, cur_n - 1));
         col = COL_W'($urandom_range(0, cur_n - 1));
      end
      roll = $urandom_range(0, 99);
      if ($urandom_range(1, mul_odds) == 1)
         start_multiply();
      else if (roll < 28)
         send_item(OP_WR_A, row, col, pick_value());
      else if (roll < 56)
         send_item(OP_WR_B, row, col, pick_value());
      else if (roll < 66)
         send_item(OP_WR_C, row, col, pick_value());
      else if (roll < 96)
         send_item(OP_RD_C, row, col, VAL_W'($urandom));
      else
         send_item(OP_W'($urandom_range(int'(OP_RD_C) + 1, int'(OP_SPARE_LAST))),
                   row, col, VAL_W'($urandom));
   endtask

   // Response side: alternate ready and stall runs; now and then a long ready run.
   initial begin
      int run;
      bit ready_run;
      rsp_tready = 1'b0;
      ready_run  = 1'b0;
      forever begin
         ready_run = !ready_run;
         if (ready_run)
            run = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
         else
            run = $urandom_range(1, 8);
         rsp_tready = ready_run;
         repeat (run) @(negedge clock);
      end
   end

   // Watchdog: end the run once nothing has moved on either channel for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int phase;
      int size_value;
      int phase_len;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tuser   = '0;
      req_tdata   = '0;
      end_of_run  = 1'b0;
      items_sent  = 0;
      burst_left  = 0;
      cur_n       = DMMA_MAX_DIM;
      mul_walk_n  = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: size zero behaves as one; C reads zero after the clearing sweep.
      set_size('0);
      send_item(OP_RD_C, '0, '0, VAL_W'($urandom));
      send_item(OP_RD_C, '1, '1, VAL_W'($urandom));
      // Extreme operands and a negative C preload.
      send_item(OP_WR_A, '0, '0, VAL_MAX);
      send_item(OP_WR_B, '0, '0, VAL_MIN);
      send_item(OP_WR_C, '0, '0, VAL_MIN);
      start_multiply();
      send_item(OP_RD_C, '0, '0, VAL_W'($urandom));
      send_item(OP_WR_C, '1, '1, VAL_MAX);
      send_item(OP_RD_C, '1, '1, VAL_W'($urandom));
      // Entries outside the size in use are stored but left alone by the multiply.
      send_item(OP_WR_C, ROW_W'(3), COL_W'(9), pick_value());
      send_item(OP_WR_A, ROW_W'(2), COL_W'(2), pick_value());
      start_multiply();
      send_item(OP_RD_C, ROW_W'(3), COL_W'(9), VAL_W'($urandom));
      send_item(OP_RD_C, '0, '0, VAL_W'($urandom));
      // Spare op codes must be dropped without a response.
      for (int s = int'(OP_RD_C) + 1; s <= int'(OP_SPARE_LAST); s++)
         send_item(OP_W'(s), ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
      // Largest product magnitude.
      set_size(SIZE_W'(1));
      send_item(OP_WR_A, '0, '0, VAL_MIN);
      send_item(OP_WR_B, '0, '0, VAL_MIN);
      start_multiply();
      send_item(OP_RD_C, '0, '0, VAL_W'($urandom));
      set_size(SIZE_W'(2));
      start_multiply();
      send_item(OP_RD_C, ROW_W'(1), '0, VAL_W'($urandom));
      send_item(OP_RD_C, '0, COL_W'(1), VAL_W'($urandom));

      // Random phases: pick a size, load and read at random, then close each phase
      // with a multiply and a read-back of the corner. Open with the full array and
      // with an oversized value, then mostly small sizes.
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         case (phase)
            0:       size_value = DMMA_MAX_DIM;
            1:       size_value = (1 << SIZE_W) - 1;
            default: begin
               case ($urandom_range(0, 9))
                  0:       size_value = $urandom_range(9, DMMA_MAX_DIM);
                  1:       size_value = $urandom_range(DMMA_MAX_DIM + 1, (1 << SIZE_W) - 1);
                  2:       size_value = 0;
                  default: size_value = $urandom_range(1, 6);
               endcase
            end
         endcase
         set_size(SIZE_W'(size_value));
         phase_len = (cur_n > 8) ? $urandom_range(60, 150) : $urandom_range(30, 100);
         repeat (phase_len) random_item();
         start_multiply();
         repeat ($urandom_range(2, 10)) corner_read();
         phase++;
      end

      // Drain: all reads back, any multiply walk done, then check for leftovers.
      settle();
      end_of_run = 1'b1;
      @(negedge clock);
      if (fail_total == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
